// ===== sv/lcdfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the LCD driver frame decoder: result kind codes, flag bit
// positions and the seven-segment and indicator decode functions.
// No dependencies.
package lcdfd_pkg;

    // Kind of frame reported with every result word.
    typedef enum logic [3:0] {
        KIND_BAD        = 4'd0,
        KIND_NONE       = 4'd1,
        KIND_DEPTH      = 4'd2,
        KIND_SHALLOW    = 4'd3,
        KIND_DEEP       = 4'd4,
        KIND_ALARM      = 4'd5,
        KIND_THRESH     = 4'd6,
        KIND_KEEL_SET   = 4'd7,
        KIND_KEEL_SHOWN = 4'd8
    } t_frame_kind;

    // Bit positions in the known mask.
    localparam int SEEN_DEPTH   = 0;
    localparam int SEEN_KEEL    = 1;
    localparam int SEEN_SHALLOW = 2;
    localparam int SEEN_DEEP    = 3;
    localparam int SEEN_THRESH  = 4;

    localparam int TENTHS_W = 10;
    localparam int MASK_W   = 5;

    // Decoded digit with a valid flag.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    // Seven-segment pattern to digit. A blank digit reads as zero.
    function automatic t_digit decode_digit(input logic [6:0] pat);
        t_digit d;
        d.valid = 1'b1;
        d.value = 4'd0;
        unique case (pat)
            7'b0000000: d.value = 4'd0;
            7'b1110111: d.value = 4'd0;
            7'b1000001: d.value = 4'd1;
            7'b1101110: d.value = 4'd2;
            7'b1101011: d.value = 4'd3;
            7'b1011001: d.value = 4'd4;
            7'b0111011: d.value = 4'd5;
            7'b0111111: d.value = 4'd6;
            7'b1100001: d.value = 4'd7;
            7'b1111111: d.value = 4'd8;
            7'b1111011: d.value = 4'd9;
            default:    d.valid = 1'b0;
        endcase
        return d;
    endfunction

    // Indicator pattern to frame kind. Blank and unknown patterns give KIND_NONE.
    function automatic t_frame_kind decode_indicator(input logic [6:0] pat);
        t_frame_kind k;
        unique case (pat)
            7'b0100000: k = KIND_SHALLOW;
            7'b0000010: k = KIND_DEEP;
            7'b1111101: k = KIND_ALARM;
            7'b0001010: k = KIND_THRESH;
            7'b0111110: k = KIND_DEPTH;
            7'b0101000: k = KIND_KEEL_SET;
            7'b0001000: k = KIND_KEEL_SHOWN;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/lcd_driver_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the LCD driver frame decoder: input register, digit and
// indicator decode, stored readings and the result register. Uses lcdfd_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one 32-bit driver frame word,
//   first received byte in bits 31 to 24. Output channel: o_out_valid /
//   i_out_stall carry one result word per frame: the frame kind, the frame's
//   decoded value in tenths, and all stored readings after this frame.
//   A word moves when valid is high and stall is low at a rising edge.
//   An accepted frame sits in the input register and is decoded into the
//   result register once that register is free, from where the receiver
//   takes it. Throughput is one frame per cycle while the receiver does not
//   stall; the single decode stage between the two registers sets that figure.
//   A frame with an invalid digit pattern changes no stored reading.
//   When the receiver stalls, the result register holds its word and the
//   input register may still take one more frame; beyond that o_in_stall
//   goes high until the result is taken.
//   Synchronous reset (i_rst_n low) empties both registers and clears all
//   stored readings, the known mask and the alarm flag.
module lcd_driver_frame_decoder
    import lcdfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_frame_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_frame_kind,
    output logic [TENTHS_W-1:0] o_decoded_tenths,
    output logic [TENTHS_W-1:0] o_depth_tenths,
    output logic [TENTHS_W-1:0] o_keel_tenths,
    output logic [TENTHS_W-1:0] o_shallow_tenths,
    output logic [TENTHS_W-1:0] o_deep_tenths,
    output logic [TENTHS_W-1:0] o_threshold_tenths,
    output logic [MASK_W-1:0]   o_known_mask,
    output logic                o_alarm_on
);

    // Input register.
    logic        r_in_valid;
    logic [31:0] r_frame;

    // Stored readings.
    logic [TENTHS_W-1:0] r_depth, r_keel, r_shallow, r_deep, r_thresh;
    logic [MASK_W-1:0]   r_seen;
    logic                r_alarm;
    logic [TENTHS_W-1:0] n_depth, n_keel, n_shallow, n_deep, n_thresh;
    logic [MASK_W-1:0]   n_seen;
    logic                n_alarm;

    // Result register.
    logic                r_out_valid;
    logic [3:0]          r_kind;
    logic [TENTHS_W-1:0] r_value;

    logic advance;
    logic take_in;

    // The result register is free when empty or being taken this cycle.
    assign advance = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign take_in = i_in_valid && !o_in_stall;

    // Gather the digit and indicator patterns from their fixed bit positions.
    logic [7:0] b0, b1, b2, b3;
    logic [6:0] ind_pat, p1, p2, p3;
    t_digit      d1, d2, d3;
    t_frame_kind ind_kind;
    logic        digits_ok;
    t_frame_kind kind;
    logic [TENTHS_W-1:0] value;

    always_comb begin
        b0 = r_frame[31:24];
        b1 = r_frame[23:16];
        b2 = r_frame[15:8];
        b3 = r_frame[7:0];
        ind_pat = {b1[2:0], b2[7], b2[5:3]};
        p1 = {b1[7:4], b2[2:0]};
        p2 = {b0[4:1], b3[7:5]};
        p3 = {b3[0], b0[7:5], b3[3:1]};
    end

    // Decode the three digits and form the value in tenths.
    always_comb begin
        d1 = decode_digit(p1);
        d2 = decode_digit(p2);
        d3 = decode_digit(p3);
        ind_kind = decode_indicator(ind_pat);
        digits_ok = d1.valid && d2.valid && d3.valid;
        if (digits_ok) begin
            kind  = ind_kind;
            value = TENTHS_W'(d1.value) * TENTHS_W'(100)
                  + TENTHS_W'(d2.value) * TENTHS_W'(10)
                  + TENTHS_W'(d3.value);
        end else begin
            kind  = KIND_BAD;
            value = '0;
        end
    end

    // Next values of the stored readings for the frame in the input register.
    always_comb begin
        n_depth   = r_depth;
        n_keel    = r_keel;
        n_shallow = r_shallow;
        n_deep    = r_deep;
        n_thresh  = r_thresh;
        n_seen    = r_seen;
        n_alarm   = r_alarm;
        unique case (kind)
            KIND_DEPTH: begin
                n_depth = value;
                n_seen[SEEN_DEPTH] = 1'b1;
            end
            KIND_SHALLOW: begin
                n_shallow = value;
                n_seen[SEEN_SHALLOW] = 1'b1;
            end
            KIND_DEEP: begin
                n_deep = value;
                n_seen[SEEN_DEEP] = 1'b1;
            end
            KIND_ALARM: begin
                n_alarm = 1'b1;
            end
            KIND_THRESH: begin
                n_thresh = value;
                n_seen[SEEN_THRESH] = 1'b1;
            end
            KIND_KEEL_SET, KIND_KEEL_SHOWN: begin
                n_keel = value;
                n_seen[SEEN_KEEL] = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control and stored state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_keel      <= '0;
            r_shallow   <= '0;
            r_deep      <= '0;
            r_thresh    <= '0;
            r_seen      <= '0;
            r_alarm     <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_depth   <= n_depth;
                r_keel    <= n_keel;
                r_shallow <= n_shallow;
                r_deep    <= n_deep;
                r_thresh  <= n_thresh;
                r_seen    <= n_seen;
                r_alarm   <= n_alarm;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_frame <= i_frame_word;
        end
        if (advance && r_in_valid) begin
            r_kind  <= kind;
            r_value <= value;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_kind       = r_kind;
    assign o_decoded_tenths   = r_value;
    assign o_depth_tenths     = r_depth;
    assign o_keel_tenths      = r_keel;
    assign o_shallow_tenths   = r_shallow;
    assign o_deep_tenths      = r_deep;
    assign o_threshold_tenths = r_thresh;
    assign o_known_mask       = r_seen;
    assign o_alarm_on         = r_alarm;

endmodule

// ===== sv/lcdfd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LCD driver frame decoder, bound to the top level.
// Uses lcdfd_pkg for the frame kind codes.
module lcdfd_checker
    import lcdfd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [3:0]          o_frame_kind,
    input logic [TENTHS_W-1:0] o_decoded_tenths,
    input logic [MASK_W-1:0]   o_known_mask,
    input logic                o_alarm_on
);

    // A stalled result word stays valid and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_decoded_tenths)))
        else $error("stalled result word changed");

    // A frame with bad digits reports a zero value.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_kind == KIND_BAD) |-> (o_decoded_tenths == '0))
        else $error("bad frame carries a nonzero value");

    // Three decimal digits never exceed 999 tenths.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_decoded_tenths <= TENTHS_W'(999)))
        else $error("decoded value out of range");

    // Once set, the alarm flag stays set until reset.
    a_alarm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_alarm_on |=> o_alarm_on)
        else $error("alarm flag cleared");

    // Known mask bits only ever get set.
    a_mask_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((o_known_mask & $past(o_known_mask)) == $past(o_known_mask)))
        else $error("known mask bit cleared");

endmodule

bind lcd_driver_frame_decoder lcdfd_checker u_lcdfd_checker (.*);

// ===== test/lcd_driver_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lcd_driver_frame_decoder. It sends driver frames with
// random idling on both channels and checks every result word against a predictor.
// Depends on lcdfd_pkg and the decoder RTL.
module lcd_driver_frame_decoder_tb;
    import lcdfd_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_WAIT      = 19;
    localparam int RANDOM_FRAMES = 1000;
    localparam int MAX_REPORTS   = 10;

    // Segment patterns that are not plain digits.
    localparam logic [6:0] SEG_BLANK = 7'b0000000;
    localparam logic [6:0] SEG_BAD   = 7'b0000001;

    // Indicator patterns.
    localparam logic [6:0] IND_BLANK      = 7'b0000000;
    localparam logic [6:0] IND_SHALLOW    = 7'b0100000;
    localparam logic [6:0] IND_DEEP       = 7'b0000010;
    localparam logic [6:0] IND_ALARM      = 7'b1111101;
    localparam logic [6:0] IND_THRESH     = 7'b0001010;
    localparam logic [6:0] IND_DEPTH      = 7'b0111110;
    localparam logic [6:0] IND_KEEL_SET   = 7'b0101000;
    localparam logic [6:0] IND_KEEL_SHOWN = 7'b0001000;
    localparam logic [6:0] IND_UNKNOWN    = 7'b1111111;

    // One result word as the decoder reports it.
    typedef struct packed {
        t_frame_kind         kind;
        logic [TENTHS_W-1:0] value;
        logic [TENTHS_W-1:0] depth;
        logic [TENTHS_W-1:0] keel;
        logic [TENTHS_W-1:0] shallow;
        logic [TENTHS_W-1:0] deep;
        logic [TENTHS_W-1:0] thresh;
        logic [MASK_W-1:0]   mask;
        logic                alarm;
    } t_readout;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [31:0]         i_frame_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [3:0]          o_frame_kind;
    logic [TENTHS_W-1:0] o_decoded_tenths;
    logic [TENTHS_W-1:0] o_depth_tenths;
    logic [TENTHS_W-1:0] o_keel_tenths;
    logic [TENTHS_W-1:0] o_shallow_tenths;
    logic [TENTHS_W-1:0] o_deep_tenths;
    logic [TENTHS_W-1:0] o_threshold_tenths;
    logic [MASK_W-1:0]   o_known_mask;
    logic                o_alarm_on;

    // Predicted readings, updated in the order frames are accepted.
    logic [TENTHS_W-1:0] track_depth = '0;
    logic [TENTHS_W-1:0] track_keel = '0;
    logic [TENTHS_W-1:0] track_shallow = '0;
    logic [TENTHS_W-1:0] track_deep = '0;
    logic [TENTHS_W-1:0] track_thresh = '0;
    logic [MASK_W-1:0]   track_mask = '0;
    logic                track_alarm = 1'b0;

    t_readout pending_readouts[$];
    int       fail_count = 0;
    int       quiet_cycles = 0;
    int       stall_left = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    logic     in_take;
    logic     out_take;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;

    lcd_driver_frame_decoder u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_frame_word       (i_frame_word),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_kind       (o_frame_kind),
        .o_decoded_tenths   (o_decoded_tenths),
        .o_depth_tenths     (o_depth_tenths),
        .o_keel_tenths      (o_keel_tenths),
        .o_shallow_tenths   (o_shallow_tenths),
        .o_deep_tenths      (o_deep_tenths),
        .o_threshold_tenths (o_threshold_tenths),
        .o_known_mask       (o_known_mask),
        .o_alarm_on         (o_alarm_on)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Seven-segment pattern of a decimal digit.
    function automatic logic [6:0] seg_of_digit(input int d);
        case (d)
            0:       return 7'b1110111;
            1:       return 7'b1000001;
            2:       return 7'b1101110;
            3:       return 7'b1101011;
            4:       return 7'b1011001;
            5:       return 7'b0111011;
            6:       return 7'b0111111;
            7:       return 7'b1100001;
            8:       return 7'b1111111;
            9:       return 7'b1111011;
            default: return SEG_BLANK;
        endcase
    endfunction

    // Digit shown by a pattern; blank reads as zero, -1 marks a pattern outside the table.
    function automatic int digit_of_seg(input logic [6:0] pat);
        int d;
        if (pat == SEG_BLANK) return 0;
        for (d = 0; d < 10; d++)
            if (seg_of_digit(d) == pat) return d;
        return -1;
    endfunction

    // Scatters the digit and indicator patterns over the frame; spare fills unused bits.
    function automatic logic [31:0] build_frame(input logic [6:0] hund, input logic [6:0] ten,
                                                input logic [6:0] unit, input logic [6:0] ind,
                                                input logic [3:0] spare);
        return {unit[5:3], ten[6:3], spare[3], hund[6:3], spare[2], ind[6:4], ind[3],
                spare[1], ind[2:0], hund[2:0], ten[2:0], spare[0], unit[2:0], unit[6]};
    endfunction

    // Frame showing a three-digit value with every digit drawn explicitly.
    function automatic logic [31:0] value_frame(input int v, input logic [6:0] ind);
        return build_frame(seg_of_digit(v / 100), seg_of_digit((v / 10) % 10),
                           seg_of_digit(v % 10), ind, 4'h0);
    endfunction

    function automatic logic [6:0] indicator_pick(input int i);
        case (i)
            0:       return IND_BLANK;
            1:       return IND_SHALLOW;
            2:       return IND_DEEP;
            3:       return IND_ALARM;
            4:       return IND_THRESH;
            5:       return IND_DEPTH;
            6:       return IND_KEEL_SET;
            default: return IND_KEEL_SHOWN;
        endcase
    endfunction

    function automatic logic [6:0] random_digit_seg();
        if ($urandom_range(0, 10) == 10) return SEG_BLANK;
        return seg_of_digit($urandom_range(0, 9));
    endfunction

    // Mostly well-formed frames, some with one broken digit and some pure noise.
    function automatic logic [31:0] random_frame();
        int         pick;
        logic [6:0] hund;
        logic [6:0] ten;
        logic [6:0] unit;
        logic [6:0] ind;
        pick = $urandom_range(0, 99);
        if (pick < 10) return $urandom();
        hund = random_digit_seg();
        ten  = random_digit_seg();
        unit = random_digit_seg();
        if (pick < 20) begin
            case ($urandom_range(0, 2))
                0:       hund = 7'($urandom_range(0, 127));
                1:       ten  = 7'($urandom_range(0, 127));
                default: unit = 7'($urandom_range(0, 127));
            endcase
        end
        if ($urandom_range(0, 9) == 0) ind = 7'($urandom_range(0, 127));
        else ind = indicator_pick($urandom_range(0, 7));
        return build_frame(hund, ten, unit, ind, 4'($urandom_range(0, 15)));
    endfunction

    // Decodes one accepted frame, updates the tracked readings and returns the
    // result word the decoder should report for it.
    function automatic t_readout predict_frame(input logic [31:0] w);
        t_readout   r;
        logic [6:0] ind;
        int         d_hund;
        int         d_ten;
        int         d_unit;
        ind    = {w[18:16], w[15], w[13:11]};
        d_hund = digit_of_seg({w[23:20], w[10:8]});
        d_ten  = digit_of_seg({w[28:25], w[7:5]});
        d_unit = digit_of_seg({w[0], w[31:29], w[3:1]});
        r.kind  = KIND_BAD;
        r.value = '0;
        if (d_hund >= 0 && d_ten >= 0 && d_unit >= 0) begin
            r.value = TENTHS_W'(d_hund * 100 + d_ten * 10 + d_unit);
            case (ind)
                IND_DEPTH: begin
                    r.kind = KIND_DEPTH;
                    track_depth = r.value;
                    track_mask[SEEN_DEPTH] = 1'b1;
                end
                IND_SHALLOW: begin
                    r.kind = KIND_SHALLOW;
                    track_shallow = r.value;
                    track_mask[SEEN_SHALLOW] = 1'b1;
                end
                IND_DEEP: begin
                    r.kind = KIND_DEEP;
                    track_deep = r.value;
                    track_mask[SEEN_DEEP] = 1'b1;
                end
                IND_THRESH: begin
                    r.kind = KIND_THRESH;
                    track_thresh = r.value;
                    track_mask[SEEN_THRESH] = 1'b1;
                end
                IND_KEEL_SET, IND_KEEL_SHOWN: begin
                    r.kind = (ind == IND_KEEL_SET) ? KIND_KEEL_SET : KIND_KEEL_SHOWN;
                    track_keel = r.value;
                    track_mask[SEEN_KEEL] = 1'b1;
                end
                IND_ALARM: begin
                    // The alarm frame only latches the flag; its value is not stored.
                    r.kind = KIND_ALARM;
                    track_alarm = 1'b1;
                end
                default: r.kind = KIND_NONE;
            endcase
        end
        r.depth   = track_depth;
        r.keel    = track_keel;
        r.shallow = track_shallow;
        r.deep    = track_deep;
        r.thresh  = track_thresh;
        r.mask    = track_mask;
        r.alarm   = track_alarm;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    endtask

    // Sends one frame word after a random gap and records its prediction on acceptance.
    // Valid stays high after acceptance so back-to-back words need no second assignment.
    task automatic send_frame(input logic [31:0] w);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_readouts.push_back(predict_frame(w));
    endtask

    // Holds off the sender until every predicted result word has arrived.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readouts.size() != 0) @(posedge i_clk);
    endtask

    // Broken digits in each position must leave every stored reading alone.
    task automatic test_bad_digits();
        send_frame(build_frame(SEG_BAD, seg_of_digit(9), seg_of_digit(9), IND_DEPTH, 4'h0));
        send_frame(build_frame(seg_of_digit(1), SEG_BAD, seg_of_digit(2), IND_SHALLOW, 4'hF));
        send_frame(build_frame(seg_of_digit(3), seg_of_digit(4), SEG_BAD, IND_ALARM, 4'hA));
        send_frame(build_frame(SEG_BAD, SEG_BAD, SEG_BAD, IND_KEEL_SET, 4'h5));
        send_frame(32'hFFFF_FFFF);
        send_frame(32'h0000_0000);
    endtask

    // A frame for each indicator but the alarm, plus blank and unknown ones, with the value extremes and blank digits.
    task automatic test_each_indicator();
        send_frame(value_frame(999, IND_DEPTH));
        send_frame(build_frame(SEG_BLANK, SEG_BLANK, SEG_BLANK, IND_SHALLOW, 4'hF));
        send_frame(value_frame(0, IND_DEEP));
        send_frame(value_frame(123, IND_THRESH));
        send_frame(value_frame(456, IND_KEEL_SET));
        send_frame(value_frame(789, IND_KEEL_SHOWN));
        send_frame(value_frame(321, IND_BLANK));
        send_frame(value_frame(111, IND_UNKNOWN));
        send_frame(build_frame(SEG_BLANK, SEG_BLANK, seg_of_digit(7), IND_DEPTH, 4'h9));
    endtask

    // The alarm flag latches and later frames of other kinds never clear it.
    task automatic test_alarm_sticky();
        send_frame(value_frame(505, IND_ALARM));
        send_frame(value_frame(42, IND_DEPTH));
        send_frame(build_frame(SEG_BAD, SEG_BLANK, SEG_BLANK, IND_ALARM, 4'h0));
        send_frame(value_frame(250, IND_ALARM));
        send_frame(value_frame(998, IND_KEEL_SHOWN));
    endtask

    // Random frames in blocks; some blocks run with no idling at all, and the
    // sender drains the decoder now and then.
    task automatic test_random_frames(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm <= ($urandom_range(0, 3) == 0);
            end
            if (i % 250 == 249) wait_for_results();
            send_frame(random_frame());
        end
        tx_calm = 1'b0;
    endtask

    // Receiver stall: after each accepted word, stall for a random number of cycles.
    always @(posedge i_clk) begin : rx_stall_gen
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (out_take) begin
            n = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left  <= n;
            i_out_stall <= (n != 0);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_readout want;
        if (i_rst_n && out_take) begin
            if (pending_readouts.size() == 0) begin
                note_failure($sformatf("result word with nothing expected, kind %0d",
                                       o_frame_kind));
            end else begin
                want = pending_readouts.pop_front();
                check_field("frame_kind", want.kind, o_frame_kind);
                check_field("decoded_tenths", want.value, o_decoded_tenths);
                check_field("depth_tenths", want.depth, o_depth_tenths);
                check_field("keel_tenths", want.keel, o_keel_tenths);
                check_field("shallow_tenths", want.shallow, o_shallow_tenths);
                check_field("deep_tenths", want.deep, o_deep_tenths);
                check_field("threshold_tenths", want.thresh, o_threshold_tenths);
                check_field("known_mask", want.mask, o_known_mask);
                check_field("alarm_on", want.alarm, o_alarm_on);
            end
        end
    end

    // Watchdog: cycles in a row in which no word moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || in_take || out_take) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : run
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_digits();
        wait_for_results();
        test_each_indicator();
        wait_for_results();
        test_alarm_sticky();
        wait_for_results();
        test_random_frames(RANDOM_FRAMES);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_readouts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
